[rtl/core/c2dvc_pkg.sv]
// ----------------------------------------------------------------------------
// c2dvc_pkg
// Shared types, sizes and helpers for the 2d valid cross-correlation block.
// ----------------------------------------------------------------------------
package c2dvc_pkg;

   // image and kernel limits
   localparam int MAX_ROWS  = 64;
   localparam int MAX_COLS  = 64;
   localparam int MAX_KROWS = 8;
   localparam int MAX_KCOLS = 8;

   // storage sizes
   localparam int KSTORE_DEPTH = MAX_KROWS * MAX_KCOLS;
   localparam int CSTORE_DEPTH = MAX_ROWS * MAX_KCOLS;
   localparam int ROW_W        = $clog2(MAX_ROWS);
   localparam int COL_W        = $clog2(MAX_COLS);
   localparam int SLOT_W       = $clog2(MAX_KCOLS);
   localparam int KIDX_W       = $clog2(MAX_KROWS);
   localparam int KADDR_W      = $clog2(KSTORE_DEPTH);
   localparam int CADDR_W      = $clog2(CSTORE_DEPTH);

   // field widths
   localparam int DIM_W    = 7;
   localparam int KDIM_W   = 4;
   localparam int SAMPLE_W = 16;
   localparam int PROD_W   = 32;
   localparam int ACC_W    = 40;
   localparam int CSR_W    = 7;

   // request op codes
   localparam logic OP_KERNEL = 1'b0;
   localparam logic OP_PIXEL  = 1'b1;

   // register indexes
   typedef enum logic [1:0] {
      CSR_IMAGE_ROWS  = 2'd0,
      CSR_IMAGE_COLS  = 2'd1,
      CSR_KERNEL_ROWS = 2'd2,
      CSR_KERNEL_COLS = 2'd3
   } csr_index_type;

   // request and response payloads
   typedef struct packed {
      logic                       op;
      logic signed [SAMPLE_W-1:0] sample;
   } req_payload_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] acc_value;
      logic [5:0]              out_row;
      logic [5:0]              out_col;
      logic                    last_out;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic accept;    // request taken this cycle
      logic start;     // request opens a window computation
      logic issue;     // read one tap from the stores
      logic load_out;  // move the sum into the response register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic win_hit;     // current request is a pixel that completes a window
      logic last_tap;    // tap counters sit on the final tap
      logic pipe_empty;  // no read or product in flight
      logic out_free;    // response register can take a new value
   } dp_status_type;

   // clamp an image dimension into 1..hi
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // clamp a kernel dimension into 1..hi
   function automatic logic [KDIM_W-1:0] clamp_kdim(input logic [KDIM_W-1:0] v,
                                                    input logic [KDIM_W-1:0] hi);
      logic [KDIM_W-1:0] r;
      if (v == '0) begin
         r = KDIM_W'(1);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

[rtl/core/c2dvc_ctrl.sv]
// ----------------------------------------------------------------------------
// c2dvc_ctrl
// Sequencer: takes requests, walks the kernel taps, waits for the MAC to drain.
// ----------------------------------------------------------------------------
module c2dvc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  c2dvc_pkg::dp_status_type status,
   output c2dvc_pkg::ctrl_cmd_type  cmd
);
   import c2dvc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_MAC   = 3'b010,
      ST_DRAIN = 3'b100
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.win_hit) state_in = ST_MAC;
         end
         ST_MAC: begin
            if (status.last_tap) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (status.pipe_empty && status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands
   assign req_ready    = (state_ff == ST_IDLE);
   assign cmd.accept   = req_ready && req_valid;
   assign cmd.start    = req_ready && req_valid && status.win_hit;
   assign cmd.issue    = (state_ff == ST_MAC);
   assign cmd.load_out = (state_ff == ST_DRAIN) && status.pipe_empty && status.out_free;

`ifndef SYNTH
   // a window start always leads into the tap walk
   a_start_to_mac: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (state_ff == ST_MAC))
      else $error("window start did not enter tap walk");

   // the final tap hands over to the drain
   a_last_tap_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC && status.last_tap) |=> (state_ff == ST_DRAIN))
      else $error("tap walk did not end after final tap");

   // no new request while products are still in flight
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> status.pipe_empty)
      else $error("request taken while mac pipeline busy");
`endif

endmodule

[rtl/core/c2dvc_dp.sv]
// ----------------------------------------------------------------------------
// c2dvc_dp
// Datapath: dimension registers, kernel and column stores, tap counters,
// one multiply-accumulate unit and the response register.
// ----------------------------------------------------------------------------
module c2dvc_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  c2dvc_pkg::csr_index_type      csr_index,
   input  logic [c2dvc_pkg::CSR_W-1:0]   csr_wr_data,
   input  c2dvc_pkg::req_payload_type    req_data,
   input  c2dvc_pkg::ctrl_cmd_type       cmd,
   output c2dvc_pkg::dp_status_type      status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output c2dvc_pkg::rsp_payload_type    rsp_data
);
   import c2dvc_pkg::*;

   // dimension registers, held clamped
   logic [DIM_W-1:0]  rows_ff, cols_ff;
   logic [KDIM_W-1:0] krows_ff, kcols_ff;

   // load and position counters
   logic [DIM_W-1:0] klc_ff, klc_in;
   logic [ROW_W-1:0] prow_ff, prow_in;
   logic [COL_W-1:0] pcol_ff, pcol_in;

   // window registers
   logic [ROW_W-1:0]  r0_ff;
   logic [COL_W-1:0]  c0_ff;
   logic              last_ff;
   logic [KIDX_W-1:0] ti_ff, ti_in;
   logic [KIDX_W-1:0] tj_ff, tj_in;
   logic [KADDR_W-1:0] kaddr_ff, kaddr_in;

   // stores
   logic signed [SAMPLE_W-1:0] kernel_mem [KSTORE_DEPTH];
   logic signed [SAMPLE_W-1:0] column_mem [CSTORE_DEPTH];

   // mac pipeline
   logic                       rd_valid_ff, mul_valid_ff;
   logic signed [SAMPLE_W-1:0] px_rd_ff, k_rd_ff;
   logic signed [PROD_W-1:0]   mul_ff;
   logic signed [ACC_W-1:0]    acc_ff;

   // response register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   // request decode
   logic             take_kernel, take_pixel;
   logic [DIM_W-1:0] ksize;
   logic [DIM_W-1:0] klc_eff;
   logic             pos_wrap;
   logic [ROW_W-1:0] row_eff;
   logic [COL_W-1:0] col_eff;
   logic [DIM_W-1:0] row_inc, col_inc;
   logic             win_hit;
   logic [CADDR_W-1:0] wr_caddr, rd_caddr;
   logic [ROW_W-1:0]   rd_row;
   logic [SLOT_W-1:0]  rd_slot;
   logic               tap_row_end, last_tap;

   assign take_kernel = cmd.accept && (req_data.op == OP_KERNEL);
   assign take_pixel  = cmd.accept && (req_data.op == OP_PIXEL);

   // kernel size and load address
   assign ksize   = DIM_W'({3'b000, krows_ff} * {3'b000, kcols_ff});
   assign klc_eff = (klc_ff >= ksize) ? '0 : klc_ff;

   // pixel position and window test
   assign pos_wrap = ({1'b0, prow_ff} >= rows_ff) || ({1'b0, pcol_ff} >= cols_ff);
   assign row_eff  = pos_wrap ? '0 : prow_ff;
   assign col_eff  = pos_wrap ? '0 : pcol_ff;
   assign row_inc  = {1'b0, row_eff} + DIM_W'(1);
   assign col_inc  = {1'b0, col_eff} + DIM_W'(1);
   assign win_hit  = (req_data.op == OP_PIXEL)
                     && (row_inc >= {3'b000, krows_ff})
                     && (col_inc >= {3'b000, kcols_ff});
   assign wr_caddr = {col_eff[SLOT_W-1:0], row_eff};

   // tap address: column slot wraps modulo the store width
   assign rd_row      = ROW_W'(r0_ff + ROW_W'(ti_ff));
   assign rd_slot     = SLOT_W'(c0_ff[SLOT_W-1:0] + tj_ff);
   assign rd_caddr    = {rd_slot, rd_row};
   assign tap_row_end = ({1'b0, ti_ff} == KDIM_W'(krows_ff - KDIM_W'(1)));
   assign last_tap    = tap_row_end && ({1'b0, tj_ff} == KDIM_W'(kcols_ff - KDIM_W'(1)));

   // next counter values
   always_comb begin
      klc_in   = klc_ff;
      prow_in  = prow_ff;
      pcol_in  = pcol_ff;
      ti_in    = ti_ff;
      tj_in    = tj_ff;
      kaddr_in = kaddr_ff;
      if (csr_wr_en) begin
         klc_in  = '0;
         prow_in = '0;
         pcol_in = '0;
      end else if (take_kernel) begin
         klc_in = klc_eff + DIM_W'(1);
      end else if (take_pixel) begin
         if (row_inc >= rows_ff) begin
            prow_in = '0;
            pcol_in = (col_inc >= cols_ff) ? '0 : COL_W'(col_inc);
         end else begin
            prow_in = ROW_W'(row_inc);
            pcol_in = col_eff;
         end
      end
      if (cmd.start) begin
         ti_in    = '0;
         tj_in    = '0;
         kaddr_in = '0;
      end else if (cmd.issue) begin
         kaddr_in = kaddr_ff + KADDR_W'(1);
         if (tap_row_end) begin
            ti_in = '0;
            tj_in = tj_ff + KIDX_W'(1);
         end else begin
            ti_in = ti_ff + KIDX_W'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= DIM_W'(MAX_ROWS);
         cols_ff      <= DIM_W'(MAX_COLS);
         krows_ff     <= KDIM_W'(3);
         kcols_ff     <= KDIM_W'(3);
         klc_ff       <= '0;
         prow_ff      <= '0;
         pcol_ff      <= '0;
         ti_ff        <= '0;
         tj_ff        <= '0;
         kaddr_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_IMAGE_ROWS:  rows_ff  <= clamp_dim(csr_wr_data, DIM_W'(MAX_ROWS));
               CSR_IMAGE_COLS:  cols_ff  <= clamp_dim(csr_wr_data, DIM_W'(MAX_COLS));
               CSR_KERNEL_ROWS: krows_ff <= clamp_kdim(csr_wr_data[KDIM_W-1:0],
                                                       KDIM_W'(MAX_KROWS));
               CSR_KERNEL_COLS: kcols_ff <= clamp_kdim(csr_wr_data[KDIM_W-1:0],
                                                       KDIM_W'(MAX_KCOLS));
               default: begin
               end
            endcase
         end
         klc_ff       <= klc_in;
         prow_ff      <= prow_in;
         pcol_ff      <= pcol_in;
         ti_ff        <= ti_in;
         tj_ff        <= tj_in;
         kaddr_ff     <= kaddr_in;
         rd_valid_ff  <= cmd.issue;
         mul_valid_ff <= rd_valid_ff;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // window origin and last flag, captured when the window opens
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         r0_ff   <= ROW_W'(row_inc - {3'b000, krows_ff});
         c0_ff   <= COL_W'(col_inc - {3'b000, kcols_ff});
         last_ff <= (row_inc == rows_ff) && (col_inc == cols_ff);
      end
   end

   // kernel store
   always_ff @(posedge clock) begin
      if (take_kernel) begin
         kernel_mem[klc_eff[KADDR_W-1:0]] <= req_data.sample;
      end
   end

   always_ff @(posedge clock) begin
      k_rd_ff <= kernel_mem[kaddr_ff];
   end

   // column store
   always_ff @(posedge clock) begin
      if (take_pixel) begin
         column_mem[wr_caddr] <= req_data.sample;
      end
   end

   always_ff @(posedge clock) begin
      px_rd_ff <= column_mem[rd_caddr];
   end

   // multiply then accumulate
   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         mul_ff <= PROD_W'(px_rd_ff) * PROD_W'(k_rd_ff);
      end
      if (cmd.start) begin
         acc_ff <= '0;
      end else if (mul_valid_ff) begin
         acc_ff <= acc_ff + ACC_W'(mul_ff);
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff.acc_value <= acc_ff;
         rsp_data_ff.out_row   <= r0_ff;
         rsp_data_ff.out_col   <= c0_ff;
         rsp_data_ff.last_out  <= last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // status
   assign status.win_hit    = win_hit;
   assign status.last_tap   = last_tap;
   assign status.pipe_empty = !rd_valid_ff && !mul_valid_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

`ifndef SYNTH
   // load count never passes the kernel store depth
   a_klc_bound: assert property (@(posedge clock) disable iff (reset)
      klc_ff <= DIM_W'(KSTORE_DEPTH))
      else $error("kernel load count beyond store depth");

   // the stored position always lies inside the image
   a_pos_inside: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, prow_ff} < rows_ff) && ({1'b0, pcol_ff} < cols_ff))
      else $error("pixel position outside image");

   // every tap read stays inside the image rows
   a_tap_row: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (({1'b0, r0_ff} + DIM_W'(ti_ff)) < rows_ff))
      else $error("tap read past last image row");

   // the response is loaded only once the accumulator has settled
   a_load_settled: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!cmd.issue && !rd_valid_ff && !mul_valid_ff))
      else $error("response loaded with products in flight");
`endif

endmodule

[rtl/core/conv2d_valid_correlate.sv]
// ----------------------------------------------------------------------------
// conv2d_valid_correlate
// Two-dimensional valid cross-correlation of a streamed image with a loaded
// kernel, Q8.8 operands and an exact Q24.16 sum in 40 bits.
// ----------------------------------------------------------------------------
// Kernel coefficients (op 0) and image pixels (op 1) arrive column-major on
// the request channel. A kernel coefficient, or a pixel that does not complete
// a window, is only written to its store. A pixel that completes a window
// occupies the block while the single multiply-accumulate unit reads one tap
// per cycle from the column store and kernel store, followed by a short
// pipeline drain. The finished sum sits in an output register, so the next
// request is taken while a response waits, and a response stalls the block
// only if the following window finishes before the previous response is
// taken. Any register write restarts the image position and the kernel load
// count; the stores need no clearing after reset, so the block is ready right
// out of reset.
// ----------------------------------------------------------------------------
module conv2d_valid_correlate (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  c2dvc_pkg::csr_index_type      csr_index,
   input  logic [c2dvc_pkg::CSR_W-1:0]   csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  c2dvc_pkg::req_payload_type    req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output c2dvc_pkg::rsp_payload_type    rsp_data
);
   import c2dvc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer
   c2dvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // stores, mac and response register
   c2dvc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
